/* src/tpu_pkg.sv */
`default_nettype none
package tpu_pkg;

  localparam int CHANNEL_SLOTS = 64;
  localparam int CH_W          = $clog2(CHANNEL_SLOTS);
  localparam int ROW_W         = 16;
  localparam int KEPT_W        = 7;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEPT_CHANNELS = 8'd1;

  localparam logic [ROW_W-1:0]  ROW_COUNT_RST = 16'd64;
  localparam logic [KEPT_W-1:0] KEPT_RST      = 7'd11;

  localparam logic [1:0] KIND_CELL      = 2'd0;
  localparam logic [1:0] KIND_ROW_END   = 2'd1;
  localparam logic [1:0] KIND_ROW_FINAL = 2'd2;

  typedef enum logic [2:0] {
    PH_CHAN  = 3'd0,
    PH_MASK  = 3'd1,
    PH_NOTE  = 3'd2,
    PH_INS   = 3'd3,
    PH_VOL   = 3'd4,
    PH_CMD   = 3'd5,
    PH_PARAM = 3'd6
  } phase_t;

  // Per-channel stored values; also the live copy for the current channel.
  typedef struct packed {
    logic [7:0] mask;
    logic [7:0] note;
    logic [7:0] instrument;
    logic [7:0] volume;
    logic [7:0] command;
    logic [7:0] param;
  } entry_t;

  typedef struct packed {
    logic            en;
    logic [CH_W-1:0] addr;
    entry_t          entry;
  } wr_t;

  // First data field still asked for after phase "from", or back to channel byte.
  function automatic phase_t next_field(input phase_t from, input logic [7:0] mask);
    phase_t p;
    p = PH_CHAN;
    if (from < PH_NOTE && mask[0]) p = PH_NOTE;
    else if (from < PH_INS && mask[1]) p = PH_INS;
    else if (from < PH_VOL && mask[2]) p = PH_VOL;
    else if (from < PH_CMD && mask[3]) p = PH_CMD;
    return p;
  endfunction

endpackage
`default_nettype wire

/* src/tpu_ifs.sv */
`default_nettype none
interface tpu_in_if import tpu_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface tpu_out_if import tpu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [ROW_W-1:0] row;
  logic [CH_W-1:0]  channel;
  logic [3:0]       write_mask;
  logic [7:0]       note;
  logic [7:0]       instrument;
  logic [7:0]       volume;
  logic [7:0]       command;
  logic [7:0]       param;
  modport source (output valid, output kind, output row, output channel, output write_mask,
                  output note, output instrument, output volume, output command,
                  output param, input ready);
  modport sink   (input valid, input kind, input row, input channel, input write_mask,
                  input note, input instrument, input volume, input command,
                  input param, output ready);
endinterface

interface tpu_cfg_if import tpu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/tpu_chan_mem.sv */
`default_nettype none
module tpu_chan_mem import tpu_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            rd_en,
  input  wire logic [CH_W-1:0] rd_addr,
  input  wire wr_t             wr,
  output entry_t               rd_entry
);

  entry_t                   mem [CHANNEL_SLOTS];
  logic [CHANNEL_SLOTS-1:0] vld_r;
  entry_t                   rd_entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
  end

  // Never-written entries read as zero.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_entry = rd_entry_r;

endmodule
`default_nettype wire

/* src/tpu_decoder.sv */
`default_nettype none
module tpu_decoder import tpu_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_mode,
  input  wire logic [7:0]        in_byte,
  input  wire entry_t            rd_entry,
  input  wire logic [ROW_W-1:0]  row_count,
  input  wire logic [KEPT_W-1:0] kept_channels,
  output logic                   fire,
  output wr_t                    wr,
  tpu_out_if.source              out_if
);

  phase_t           phase_r, phase_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic             kept_r, kept_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             done_r, done_nxt;
  entry_t           cur_r, cur_nxt;

  logic             out_valid_r;
  logic [1:0]       kind_r;
  logic [ROW_W-1:0] orow_r;
  logic [CH_W-1:0]  och_r;
  logic [3:0]       wm_r;
  logic [7:0]       note_r, ins_r, vol_r, cmd_r, par_r;

  logic             emit;
  logic [1:0]       emit_kind;
  logic [3:0]       emit_wm;

  logic [CH_W-1:0]  new_ch;
  logic             kept_new;
  entry_t           load;
  phase_t           from_ph;
  logic [7:0]       mask_src;
  phase_t           np;
  logic             row_last;
  logic             work;

  assign fire     = in_valid && (!out_valid_r || out_if.ready);
  assign work     = fire && !in_mode && !done_r;
  assign new_ch   = in_byte[CH_W-1:0] - {{(CH_W-1){1'b0}}, 1'b1};
  assign kept_new = {1'b0, new_ch} < kept_channels;
  // The live copy is newer than the memory for the channel just written.
  assign load     = (new_ch == ch_r) ? cur_r : rd_entry;
  assign row_last = ({1'b0, row_r} + 17'd1) >= {1'b0, row_count};

  always_comb begin
    case (phase_r)
      PH_CHAN: begin
        from_ph  = PH_MASK;
        mask_src = load.mask;
      end
      PH_MASK: begin
        from_ph  = PH_MASK;
        mask_src = in_byte;
      end
      default: begin
        from_ph  = phase_r;
        mask_src = cur_r.mask;
      end
    endcase
  end

  assign np = next_field(from_ph, mask_src);

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    ch_nxt    = ch_r;
    kept_nxt  = kept_r;
    row_nxt   = row_r;
    done_nxt  = done_r;
    cur_nxt   = cur_r;
    if (fire && in_mode) begin
      phase_nxt = PH_CHAN;
      row_nxt   = '0;
      done_nxt  = 1'b0;
    end else if (work) begin
      case (phase_r)
        PH_CHAN: begin
          if (in_byte == 8'd0) begin
            if (row_last) done_nxt = 1'b1;
            else          row_nxt  = row_r + 16'd1;
          end else begin
            ch_nxt   = new_ch;
            kept_nxt = kept_new;
            cur_nxt  = load;
            phase_nxt = in_byte[7] ? PH_MASK : np;
          end
        end
        PH_MASK: begin
          cur_nxt.mask = in_byte;
          phase_nxt    = np;
        end
        PH_NOTE: begin
          if (kept_r) cur_nxt.note = in_byte;
          phase_nxt = np;
        end
        PH_INS: begin
          if (kept_r) cur_nxt.instrument = in_byte;
          phase_nxt = np;
        end
        PH_VOL: begin
          if (kept_r) cur_nxt.volume = in_byte;
          phase_nxt = np;
        end
        PH_CMD: begin
          if (kept_r) cur_nxt.command = in_byte;
          phase_nxt = PH_PARAM;
        end
        PH_PARAM: begin
          if (kept_r) cur_nxt.param = in_byte;
          phase_nxt = PH_CHAN;
        end
        default: phase_nxt = PH_CHAN;
      endcase
    end
  end

  // Outputs
  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_CELL;
    if (work) begin
      case (phase_r)
        PH_CHAN: begin
          if (in_byte == 8'd0) begin
            emit      = 1'b1;
            emit_kind = row_last ? KIND_ROW_FINAL : KIND_ROW_END;
          end else begin
            emit = !in_byte[7] && (np == PH_CHAN) && kept_new;
          end
        end
        PH_MASK, PH_NOTE, PH_INS, PH_VOL: emit = (np == PH_CHAN) && kept_r;
        PH_PARAM: emit = kept_r;
        default:  emit = 1'b0;
      endcase
    end
  end

  assign emit_wm = cur_nxt.mask[3:0] | cur_nxt.mask[7:4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CHAN;
      ch_r        <= '0;
      kept_r      <= 1'b0;
      row_r       <= '0;
      done_r      <= 1'b0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      ch_r    <= ch_nxt;
      kept_r  <= kept_nxt;
      row_r   <= row_nxt;
      done_r  <= done_nxt;
      cur_r   <= cur_nxt;
      if (fire)              out_valid_r <= emit;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      kind_r <= emit_kind;
      orow_r <= row_r;
      if (emit_kind == KIND_CELL) begin
        och_r  <= ch_nxt;
        wm_r   <= emit_wm;
        note_r <= emit_wm[0] ? cur_nxt.note : 8'd0;
        ins_r  <= emit_wm[1] ? cur_nxt.instrument : 8'd0;
        vol_r  <= emit_wm[2] ? cur_nxt.volume : 8'd0;
        cmd_r  <= emit_wm[3] ? cur_nxt.command : 8'd0;
        par_r  <= emit_wm[3] ? cur_nxt.param : 8'd0;
      end else begin
        och_r  <= '0;
        wm_r   <= '0;
        note_r <= '0;
        ins_r  <= '0;
        vol_r  <= '0;
        cmd_r  <= '0;
        par_r  <= '0;
      end
    end
  end

  // Write back the live copy on every consumed word.
  assign wr.en    = fire;
  assign wr.addr  = ch_nxt;
  assign wr.entry = cur_nxt;

  assign out_if.valid      = out_valid_r;
  assign out_if.kind       = kind_r;
  assign out_if.row        = orow_r;
  assign out_if.channel    = och_r;
  assign out_if.write_mask = wm_r;
  assign out_if.note       = note_r;
  assign out_if.instrument = ins_r;
  assign out_if.volume     = vol_r;
  assign out_if.command    = cmd_r;
  assign out_if.param      = par_r;

endmodule
`default_nettype wire

/* src/tracker_pattern_unpacker_core.sv */
// Packed pattern body decoder.
// in_if carries one word per byte: mode 1 starts a new pattern (row and phase
// cleared, channel tables kept), mode 0 carries a packed data byte.
// out_if returns at most one word per input byte: a cell record with its
// write mask and values, a row end marker, or the final row marker, after
// which data bytes are dropped until the next new-pattern word.
// cfg_if writes row_count (index 0) and kept_channels (index 1); it is always
// ready and a write takes effect at once. Other indexes are dropped.
// Throughput: one byte per cycle while the receiver does not stall. The accepting
// edge loads the input register and the registered read of the 64-entry
// per-channel table; the phase update then loads the result register, which
// drives out_if.valid.
// A stalled receiver holds the result register; one more byte waits in the
// input register, then in_if.ready drops.
// Reset clears phase, row, pattern state and the table valid bits, so every
// channel reads as all zero; no clearing pass is needed. Registers return to
// row_count 64 and kept_channels 11.
`default_nettype none
module tracker_pattern_unpacker_core import tpu_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  tpu_cfg_if.sink   cfg_if,
  tpu_in_if.sink    in_if,
  tpu_out_if.source out_if
);

  logic [ROW_W-1:0]  row_count_r;
  logic [KEPT_W-1:0] kept_r;

  logic       in_valid_r;
  logic       in_mode_r;
  logic [7:0] in_byte_r;
  logic       in_take;
  logic       fire;
  wr_t        wr;
  entry_t     rd_entry;
  logic [CH_W-1:0] rd_addr;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RST;
      kept_r      <= KEPT_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_ROW_COUNT:     row_count_r <= cfg_if.data[ROW_W-1:0];
        REG_KEPT_CHANNELS: kept_r      <= cfg_if.data[KEPT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = !in_valid_r || fire;
  assign in_take     = in_if.valid && in_if.ready;
  // Read ahead as if the word were a channel byte.
  assign rd_addr     = in_if.data_byte[CH_W-1:0] - {{(CH_W-1){1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_mode_r <= in_if.mode;
      in_byte_r <= in_if.data_byte;
    end
  end

  tpu_chan_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_take),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .rd_entry (rd_entry)
  );

  tpu_decoder u_dec (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid_r),
    .in_mode       (in_mode_r),
    .in_byte       (in_byte_r),
    .rd_entry      (rd_entry),
    .row_count     (row_count_r),
    .kept_channels (kept_r),
    .fire          (fire),
    .wr            (wr),
    .out_if        (out_if)
  );

endmodule
`default_nettype wire
